[rtl/core/fire_reload_retry_sequencer_defines.svh]
// Assertion macros shared by the sequencer RTL.
`ifndef FIRE_RELOAD_RETRY_SEQUENCER_DEFINES_SVH
`define FIRE_RELOAD_RETRY_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FRRS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FRRS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/frrs_pkg.sv]
// Package: widths, codes and register indexes of the fire/reload sequencer.
`default_nettype none

package frrs_pkg;

  // field widths
  localparam int PosW    = 24;
  localparam int VelW    = 12;
  localparam int SpdW    = 10;
  localparam int TimerW  = 16;
  localparam int TickW   = 10;
  localparam int AttW    = 4;
  localparam int TolW    = 16;
  localparam int CmdW    = 2;
  localparam int PhaseW  = 2;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 24;
  localparam int InDataW = 40;
  localparam int OutDataW = 40;

  // phase codes
  localparam logic [PhaseW-1:0] PH_IDLE   = 2'd0;
  localparam logic [PhaseW-1:0] PH_FIRING = 2'd1;
  localparam logic [PhaseW-1:0] PH_RELOAD = 2'd2;

  // move command codes
  localparam logic [CmdW-1:0] CMD_NONE = 2'd0;
  localparam logic [CmdW-1:0] CMD_FIRE = 2'd1;
  localparam logic [CmdW-1:0] CMD_LOAD = 2'd2;

  // request kinds
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_FIRE_POS  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LOAD_POS  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MOVE_SPD  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_STALL_LIM = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TICK_MS   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ATT_LIM   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_POS_TOL   = 3'd6;

  // fixed thresholds
  localparam logic signed [PosW+1:0] SHOT_MARGIN = 26'sd25;
  localparam logic signed [VelW-1:0] SLOW_RPM    = 12'sd5;
  localparam logic [AttW-1:0]        ATT_MAX     = 4'd15;
  localparam logic [TimerW-1:0]      TIMER_MAX   = 16'hFFFF;

  // one result beat
  typedef struct packed {
    logic              start_ignored;
    logic [AttW-1:0]   attempts_used;
    logic              shot_done;
    logic [PhaseW-1:0] phase_now;
    logic [PosW-1:0]   move_target;
    logic [CmdW-1:0]   move_command;
  } result_t;

  localparam int ResW = $bits(result_t);

endpackage

`default_nettype wire

[rtl/core/fire_reload_retry_sequencer.sv]
// Top level: fire/reload/retry actuator sequencer with stream ports.
`default_nettype none
`include "fire_reload_retry_sequencer_defines.svh"

// One result beat per input beat, one input beat per clock while s_tready is
// high. A start request or sensor tick is evaluated in the cycle it is taken
// and its result goes to the output register, or to the skid when stalled. The
// output register is backed by a one-beat skid buffer: the input stays ready
// while a single result waits, and drops ready only when both are full.
// Phase, attempt count, success flag and stall timer update at the accept
// edge, so back-to-back ticks see each other's effects. Move speed is taken
// on the configuration port but carried by no result field.
module fire_reload_retry_sequencer (
  input  wire                         clk,
  input  wire                         rst,
  // configuration write port
  input  wire                         cfg_we,
  input  wire [frrs_pkg::CfgIdxW-1:0] cfg_index,
  input  wire [frrs_pkg::CfgW-1:0]    cfg_data,
  // input stream
  input  wire                         s_tvalid,
  output logic                        s_tready,
  input  wire [frrs_pkg::InDataW-1:0] s_tdata,   // [23:0] arm_position, [35:24] arm_velocity
  input  wire                         s_tuser,   // [0] req_type
  // result stream
  output logic                        m_tvalid,
  input  wire                         m_tready,
  output logic [frrs_pkg::OutDataW-1:0] m_tdata  // [1:0] move_command, [25:2] move_target,
                                                 // [27:26] phase_now, [28] shot_done,
                                                 // [32:29] attempts_used, [33] start_ignored
);
  import frrs_pkg::*;

  // configuration registers
  logic signed [PosW-1:0] fire_position;
  logic signed [PosW-1:0] load_position;
  logic [TimerW-1:0]      stall_limit_ms;
  logic [TickW-1:0]       tick_period_ms;
  logic [AttW-1:0]        attempt_limit;
  logic [TolW-1:0]        reload_window;

  // sequencer state
  logic [PhaseW-1:0] phase, phase_next;
  logic [AttW-1:0]   failed_attempts, failed_attempts_next;
  logic              success_flag, success_flag_next;
  logic [TimerW-1:0] stall_timer, stall_timer_next;

  // output register and skid
  result_t out_reg, skid_reg, res;
  logic    skid_valid;

  // step datapath
  logic                   accept;
  logic signed [PosW-1:0] arm_position;
  logic signed [VelW-1:0] arm_velocity;
  logic signed [PosW+1:0] fire_sum;
  logic signed [PosW+1:0] load_diff;
  logic [PosW+1:0]        load_dist;
  logic                   shot_hit;
  logic                   near_load;
  logic                   arm_slow;
  logic [TimerW:0]        stall_sum;
  logic [TimerW-1:0]      stall_upd;
  logic [AttW-1:0]        att_inc;
  logic                   finish;

  assign arm_position = s_tdata[PosW-1:0];
  assign arm_velocity = s_tdata[PosW+VelW-1:PosW];
  assign s_tready     = !skid_valid;
  assign accept       = s_tvalid && s_tready;

  // configuration writes; move speed has no effect on any result
  always_ff @(posedge clk) begin
    if (rst) begin
      fire_position  <= '0;
      load_position  <= '0;
      stall_limit_ms <= 16'd500;
      tick_period_ms <= 10'd20;
      attempt_limit  <= 4'd3;
      reload_window  <= 16'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRE_POS:  fire_position  <= cfg_data[PosW-1:0];
        REG_LOAD_POS:  load_position  <= cfg_data[PosW-1:0];
        REG_MOVE_SPD:  ;
        REG_STALL_LIM: stall_limit_ms <= cfg_data[TimerW-1:0];
        REG_TICK_MS:   tick_period_ms <= cfg_data[TickW-1:0];
        REG_ATT_LIM:   attempt_limit  <= cfg_data[AttW-1:0];
        REG_POS_TOL:   reload_window  <= cfg_data[TolW-1:0];
        default:       ;
      endcase
    end
  end

  // compares and sums shared by the step
  assign fire_sum  = {{2{fire_position[PosW-1]}}, fire_position} + SHOT_MARGIN;
  assign shot_hit  = $signed({{2{arm_position[PosW-1]}}, arm_position}) <= fire_sum;
  assign load_diff = {{2{arm_position[PosW-1]}}, arm_position}
                   - {{2{load_position[PosW-1]}}, load_position};
  assign load_dist = load_diff[PosW+1] ? (~load_diff + 26'd1) : load_diff;
  assign near_load = load_dist < {{(PosW+2-TolW){1'b0}}, reload_window};
  assign arm_slow  = (arm_velocity < SLOW_RPM) && (arm_velocity > -SLOW_RPM);
  assign stall_sum = {1'b0, stall_timer} + {{(TimerW+1-TickW){1'b0}}, tick_period_ms};
  assign stall_upd = !arm_slow ? '0 :
                     (stall_sum[TimerW] ? TIMER_MAX : stall_sum[TimerW-1:0]);
  assign att_inc   = (failed_attempts == ATT_MAX) ? ATT_MAX : failed_attempts + 4'd1;

  // next state and result for the beat on the input
  always_comb begin
    phase_next           = phase;
    failed_attempts_next = failed_attempts;
    success_flag_next    = success_flag;
    stall_timer_next     = stall_timer;
    finish               = 1'b0;
    res                  = '0;
    res.move_command     = CMD_NONE;
    if (s_tuser == REQ_START) begin
      if (phase == PH_FIRING || phase == PH_RELOAD) begin
        res.start_ignored = 1'b1;
      end else begin
        failed_attempts_next = '0;
        stall_timer_next     = '0;
        success_flag_next    = 1'b0;
        phase_next           = PH_FIRING;
        res.move_command     = CMD_FIRE;
        res.move_target      = fire_position;
      end
    end else begin
      case (phase)
        PH_FIRING: begin
          if (shot_hit) begin
            success_flag_next = 1'b1;
            phase_next        = PH_RELOAD;
            res.move_command  = CMD_LOAD;
            res.move_target   = load_position;
          end else begin
            stall_timer_next = stall_upd;
            if (stall_upd >= stall_limit_ms) begin
              phase_next       = PH_RELOAD;
              res.move_command = CMD_LOAD;
              res.move_target  = load_position;
            end
          end
        end
        PH_RELOAD: begin
          if (near_load) begin
            if (success_flag) begin
              finish = 1'b1;
            end else begin
              failed_attempts_next = att_inc;
              finish               = att_inc >= attempt_limit;
            end
            if (finish) begin
              phase_next           = PH_IDLE;
              failed_attempts_next = '0;
              success_flag_next    = 1'b0;
            end else begin
              phase_next       = PH_FIRING;
              stall_timer_next = '0;
              res.move_command = CMD_FIRE;
              res.move_target  = fire_position;
            end
          end
        end
        default: ;
      endcase
    end
    res.phase_now     = phase_next;
    res.shot_done     = success_flag_next;
    res.attempts_used = failed_attempts_next;
  end

  // state update on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      failed_attempts <= '0;
      success_flag    <= 1'b0;
      stall_timer     <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      failed_attempts <= failed_attempts_next;
      success_flag    <= success_flag_next;
      stall_timer     <= stall_timer_next;
    end
  end

  // output register with one-beat skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      out_reg <= skid_valid ? skid_reg : res;
    end else if (accept) begin
      skid_reg <= res;
    end
  end

  assign m_tdata = {{(OutDataW-ResW){1'b0}}, out_reg};

  // checks
  `FRRS_ASSERT_IMP(a_skid_behind_out, clk, rst, skid_valid, m_tvalid,
                   "skid holds a beat while output register is empty")
  `FRRS_ASSERT_NXT(a_beat_reaches_out, clk, rst,
                   accept && (m_tready || !m_tvalid), m_tvalid,
                   "accepted beat did not reach output register")
  `FRRS_ASSERT_IMP(a_idle_clean, clk, rst, phase == PH_IDLE,
                   failed_attempts == '0 && !success_flag,
                   "idle phase with stale attempt count or success flag")
  `FRRS_ASSERT_IMP(a_success_reload, clk, rst, success_flag, phase == PH_RELOAD,
                   "success flag set outside reloading")

endmodule

`default_nettype wire
